@@ rtl/core/gf2mm_pkg.sv @@
// Shared widths, defaults and the modulus control struct for gf2_poly_mulmod.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package gf2mm_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned ProdW  = 2 * DataW;
  localparam int unsigned ShiftW = $clog2(DataW);
  // Product shifted up so that the normalized modulus sits with its top bit at DataW-1.
  localparam int unsigned ExtW   = ProdW + DataW - 1;

  localparam int unsigned MulBitsDef = 8;
  localparam int unsigned RedBitsDef = 4;

  localparam logic [DataW-1:0] TopBit = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [DataW-1:0]  dn;    // modulus shifted so its highest set bit is at DataW-1
    logic [ShiftW-1:0] s;     // shift applied, equal to DataW-1 minus the degree
    logic              bad;   // modulus is zero
    logic              busy;  // normalization still running
  } norm_t;

endpackage

`default_nettype wire

@@ rtl/core/gf2_poly_mulmod.sv @@
// Top level of the GF(2) 64-bit multiply-and-reduce pipeline.
// Depends on gf2mm_pkg, gf2mm_norm, gf2mm_mul_cell and gf2mm_red_cell.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries factor_a_i and factor_b_i; output channel
//   out_valid_o/out_ready_i carries remainder_o and bad_modulus_o, one beat per input beat,
//   in order. modulus_poly_we_i writes modulus_poly_i with no handshake.
//   The path runs through a chain of multiplier cells, one alignment stage, a chain of
//   reduction cells and the output register. Throughput is one beat per cycle while the
//   receiver is ready and the normalizer is idle; each cell holds one beat and has its own
//   valid bit, so when the receiver stalls the chain keeps filling its empty cells and
//   still takes input until every cell is occupied.
//   After a modulus write the normalizer runs a binary search for the highest set bit;
//   in_ready_o is low during that time.
//   Reset empties the chain and sets the modulus to zero. With a zero modulus every
//   result is zero with bad_modulus_o set.
`default_nettype none

module gf2_poly_mulmod #(
  parameter int unsigned MulBits = gf2mm_pkg::MulBitsDef,
  parameter int unsigned RedBits = gf2mm_pkg::RedBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        modulus_poly_we_i,
  input  wire logic [gf2mm_pkg::DataW-1:0] modulus_poly_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [gf2mm_pkg::DataW-1:0] factor_a_i,
  input  wire logic [gf2mm_pkg::DataW-1:0] factor_b_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [gf2mm_pkg::DataW-1:0]      remainder_o,
  output logic                             bad_modulus_o
);
  import gf2mm_pkg::*;

  localparam int unsigned NumMul = DataW / MulBits;
  localparam int unsigned NumRed = ProdW / RedBits;

  norm_t norm;

  logic             mul_valid [NumMul+1];
  logic             mul_ready [NumMul+1];
  logic [DataW-1:0] mul_a     [NumMul+1];
  logic [DataW-1:0] mul_b     [NumMul+1];
  logic [ProdW-1:0] mul_acc   [NumMul+1];

  logic            red_valid [NumRed+1];
  logic            red_ready [NumRed+1];
  logic [ExtW-1:0] red_acc   [NumRed+1];

  logic            al_valid_q;
  logic            al_ready;
  logic [ExtW-1:0] al_acc_q;

  logic             out_valid_q;
  logic             out_rdy;
  logic [DataW-1:0] rem_q, rem_d;
  logic             bad_q;

  gf2mm_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (modulus_poly_we_i),
    .data_i (modulus_poly_i),
    .norm_o (norm)
  );

  assign mul_valid[0] = in_valid_i && !norm.busy;
  assign in_ready_o   = mul_ready[0] && !norm.busy;
  assign mul_a[0]     = factor_a_i;
  assign mul_b[0]     = factor_b_i;
  assign mul_acc[0]   = '0;

  for (genvar j = 0; j < NumMul; j++) begin : g_mul
    gf2mm_mul_cell #(
      .MulBits (MulBits),
      .Base    (j * MulBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (mul_valid[j]),
      .ready_o (mul_ready[j]),
      .a_i     (mul_a[j]),
      .b_i     (mul_b[j]),
      .acc_i   (mul_acc[j]),
      .valid_o (mul_valid[j+1]),
      .ready_i (mul_ready[j+1]),
      .a_o     (mul_a[j+1]),
      .b_o     (mul_b[j+1]),
      .acc_o   (mul_acc[j+1])
    );
  end

  // Alignment stage: multiplying the product by x^s keeps the reduction position-fixed.
  assign mul_ready[NumMul] = al_ready;
  assign al_ready          = !al_valid_q || red_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      al_valid_q <= 1'b0;
    end else if (al_ready) begin
      al_valid_q <= mul_valid[NumMul];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid[NumMul] && al_ready) begin
      al_acc_q <= {{(ExtW - ProdW){1'b0}}, mul_acc[NumMul]} << norm.s;
    end
  end

  assign red_valid[0] = al_valid_q;
  assign red_acc[0]   = al_acc_q;

  for (genvar j = 0; j < NumRed; j++) begin : g_red
    gf2mm_red_cell #(
      .RedBits (RedBits),
      .TopPos  (ExtW - 1 - j * RedBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (red_valid[j]),
      .ready_o (red_ready[j]),
      .acc_i   (red_acc[j]),
      .dn_i    (norm.dn),
      .valid_o (red_valid[j+1]),
      .ready_i (red_ready[j+1]),
      .acc_o   (red_acc[j+1])
    );
  end

  // Output stage: undo the alignment shift; a zero modulus forces a zero result.
  assign red_ready[NumRed] = out_rdy;
  assign out_rdy           = !out_valid_q || out_ready_i;

  always_comb begin
    rem_d = {1'b0, red_acc[NumRed][DataW-2:0] >> norm.s};
    if (norm.bad) begin
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= red_valid[NumRed];
    end
  end

  always_ff @(posedge clk_i) begin
    if (red_valid[NumRed] && out_rdy) begin
      rem_q <= rem_d;
      bad_q <= norm.bad;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign remainder_o   = rem_q;
  assign bad_modulus_o = bad_q;

endmodule

`default_nettype wire

@@ rtl/core/gf2mm_norm.sv @@
// Modulus register and its normalizer: a binary search over six steps that shifts the
// modulus up until its highest set bit is at the top. Depends on gf2mm_pkg.
`default_nettype none

module gf2mm_norm (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     we_i,
  input  wire logic [gf2mm_pkg::DataW-1:0] data_i,
  output gf2mm_pkg::norm_t              norm_o
);
  import gf2mm_pkg::*;

  localparam int unsigned Steps = ShiftW;
  localparam int unsigned StepW = $clog2(Steps);

  logic [DataW-1:0]  work_q, work_d;
  logic [ShiftW-1:0] s_q, s_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              busy_q, busy_d;
  logic              bad_q, bad_d;
  logic [ShiftW-1:0] amt;
  logic              top_zero;

  always_comb begin
    amt      = ShiftW'(DataW / 2) >> step_q;
    top_zero = (work_q & ~({DataW{1'b1}} >> amt)) == '0;
    work_d   = work_q;
    s_d      = s_q;
    step_d   = step_q;
    busy_d   = busy_q;
    bad_d    = bad_q;
    if (we_i) begin
      work_d = data_i;
      s_d    = '0;
      step_d = '0;
      busy_d = 1'b1;
      bad_d  = (data_i == '0);
    end else if (busy_q) begin
      if (top_zero) begin
        work_d = work_q << amt;
        s_d    = s_q + amt;
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(Steps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      s_q    <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      bad_q  <= 1'b1;
    end else begin
      work_q <= work_d;
      s_q    <= s_d;
      step_q <= step_d;
      busy_q <= busy_d;
      bad_q  <= bad_d;
    end
  end

  assign norm_o = '{dn: work_q, s: s_q, bad: bad_q, busy: busy_q};

endmodule

`default_nettype wire

@@ rtl/core/gf2mm_mul_cell.sv @@
// One cell of the carry-less multiplier chain: folds MulBits bits of factor a into the
// partial product and hands both factors on. Depends on gf2mm_pkg.
`default_nettype none

module gf2mm_mul_cell #(
  parameter int unsigned MulBits = gf2mm_pkg::MulBitsDef,
  parameter int unsigned Base    = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [gf2mm_pkg::DataW-1:0]  a_i,
  input  wire logic [gf2mm_pkg::DataW-1:0]  b_i,
  input  wire logic [gf2mm_pkg::ProdW-1:0]  acc_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output logic [gf2mm_pkg::DataW-1:0]       a_o,
  output logic [gf2mm_pkg::DataW-1:0]       b_o,
  output logic [gf2mm_pkg::ProdW-1:0]       acc_o
);
  import gf2mm_pkg::*;

  logic             valid_q;
  logic [DataW-1:0] a_q, b_q;
  logic [ProdW-1:0] acc_q, acc_d;

  // The shifted copies of b are independent, so this is a flat XOR tree.
  always_comb begin
    acc_d = acc_i;
    for (int i = 0; i < int'(MulBits); i++) begin
      if (a_i[Base + i]) begin
        acc_d = acc_d ^ ({{DataW{1'b0}}, b_i} << (Base + i));
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign acc_o   = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/gf2mm_red_cell.sv @@
// One cell of the reduction chain: clears RedBits product bits from TopPos downward by
// XORing in the normalized modulus where a bit is set. Depends on gf2mm_pkg.
`default_nettype none

module gf2mm_red_cell #(
  parameter int unsigned RedBits = gf2mm_pkg::RedBitsDef,
  parameter int unsigned TopPos  = gf2mm_pkg::ExtW - 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire logic [gf2mm_pkg::ExtW-1:0]  acc_i,
  input  wire logic [gf2mm_pkg::DataW-1:0] dn_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [gf2mm_pkg::ExtW-1:0]       acc_o
);
  import gf2mm_pkg::*;

  logic            valid_q;
  logic [ExtW-1:0] acc_q, acc_d;

  // The modulus has its top bit set, so each step clears the bit it tests.
  always_comb begin
    acc_d = acc_i;
    for (int i = 0; i < int'(RedBits); i++) begin
      if (acc_d[TopPos - i]) begin
        acc_d[TopPos - i - (DataW - 1) +: DataW] =
          acc_d[TopPos - i - (DataW - 1) +: DataW] ^ dn_i;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      acc_q <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/gf2mm_checker.sv @@
// Port-level checks for gf2_poly_mulmod and the bind that attaches them.
// Depends on gf2mm_pkg and on the top level's port list.
`default_nettype none

module gf2mm_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        modulus_poly_we_i,
  input wire logic [gf2mm_pkg::DataW-1:0] modulus_poly_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [gf2mm_pkg::DataW-1:0] remainder_o,
  input wire logic                        bad_modulus_o
);
  import gf2mm_pkg::*;

  logic [DataW-1:0] mod_q;
  logic [DataW-1:0] smear;
  logic [DataW-1:0] below;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= '0;
    end else if (modulus_poly_we_i) begin
      mod_q <= modulus_poly_i;
    end
  end

  // Every bit at or below the modulus's highest set bit; shifted once, the allowed bits.
  always_comb begin
    smear = mod_q;
    for (int i = 1; i < int'(DataW); i = i * 2) begin
      smear = smear | (smear >> i);
    end
    below = smear >> 1;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(remainder_o))
    else $error("result beat changed while stalled");

  a_bad_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bad_modulus_o == (mod_q == '0))
    else $error("bad_modulus does not match the modulus register");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_modulus_o |-> remainder_o == '0)
    else $error("nonzero remainder with a zero modulus");

  a_degree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_modulus_o |-> (remainder_o & ~below) == '0)
    else $error("remainder degree not below modulus degree");

endmodule

bind gf2_poly_mulmod gf2mm_checker u_gf2mm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .modulus_poly_we_i (modulus_poly_we_i),
  .modulus_poly_i    (modulus_poly_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .remainder_o       (remainder_o),
  .bad_modulus_o     (bad_modulus_o)
);

`default_nettype wire
